// File: hw/rtl/lfbs_pkg.sv
`default_nettype none

package lfbs_pkg;

   // field widths
   localparam int unsigned STEP_W     = 13;
   localparam int unsigned INTERVAL_W = 8;
   localparam int unsigned UNIT_W     = 16;
   localparam int unsigned PEAK_W     = 8;
   localparam int unsigned FLASH_W    = 5;
   localparam int unsigned WAIT_W     = 4;
   localparam int unsigned LEVEL_W    = 8;
   localparam int unsigned PHASE_W    = 3;
   localparam int unsigned ELAPSED_W  = 20;
   localparam int unsigned BRIGHT_W   = 18;   // signed q9.8
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_START = 3'd1;
   localparam logic [PHASE_W-1:0] PH_UP    = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DOWN  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_COUNT = 3'd4;
   localparam logic [PHASE_W-1:0] PH_PAUSE = 3'd5;

   // register indexes
   localparam logic [2:0] REG_STEP_SIZE     = 3'd0;
   localparam logic [2:0] REG_STEP_INTERVAL = 3'd1;
   localparam logic [2:0] REG_IDLE_UNIT     = 3'd2;
   localparam logic [2:0] REG_PAUSE_UNIT    = 3'd3;
   localparam logic [2:0] REG_PEAK_LEVEL    = 3'd4;

   // reset values
   localparam logic [STEP_W-1:0]     STEP_SIZE_RST     = 13'd1280;
   localparam logic [INTERVAL_W-1:0] STEP_INTERVAL_RST = 8'd10;
   localparam logic [UNIT_W-1:0]     IDLE_UNIT_RST     = 16'd300;
   localparam logic [UNIT_W-1:0]     PAUSE_UNIT_RST    = 16'd1000;
   localparam logic [PEAK_W-1:0]     PEAK_LEVEL_RST    = 8'd250;
   localparam logic [WAIT_W-1:0]     WAIT_MULT_RST     = 4'd5;
   localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX       = 20'hFFFFF;

   typedef struct packed {
      logic [STEP_W-1:0]     step_size;
      logic [INTERVAL_W-1:0] step_interval_ms;
      logic [UNIT_W-1:0]     idle_unit_ms;
      logic [UNIT_W-1:0]     pause_unit_ms;
      logic [PEAK_W-1:0]     peak_level;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] pwm_level;
      logic               level_updated;
      logic [PHASE_W-1:0] phase;
   } rsp_data_type;

endpackage

`default_nettype wire

// File: hw/rtl/lfbs_req_if.sv
`default_nettype none

interface lfbs_req_if import lfbs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               ms_elapsed;
   logic [FLASH_W-1:0] rand_flashes;
   logic [WAIT_W-1:0]  rand_wait;

   modport source (output valid, output ms_elapsed, output rand_flashes,
                   output rand_wait, input ready);
   modport sink (input valid, input ms_elapsed, input rand_flashes,
                 input rand_wait, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lfbs_rsp_if.sv
`default_nettype none

interface lfbs_rsp_if import lfbs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] pwm_level;
   logic               level_updated;
   logic [PHASE_W-1:0] phase;

   modport source (output valid, output pwm_level, output level_updated,
                   output phase, input ready);
   modport sink (input valid, input pwm_level, input level_updated,
                 input phase, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/led_flash_burst_sequencer.sv
`default_nettype none
// Channel   Dir  Handshake      Payload
// req_port  in   valid/ready    ms_elapsed, rand_flashes, rand_wait
// rsp_port  out  valid/ready    pwm_level, level_updated, phase
// csr       in   APB, pready=1  step_size, step_interval_ms, idle_unit_ms,
//                               pause_unit_ms, peak_level at 0x00..0x10
//
// One word in, one word out: the state update and the result
// are computed in the cycle a word is accepted and the result lands in the
// output register. A new word is taken every cycle while the output register
// is empty or being drained; a stalled result holds req_port.ready low.
// Synchronous reset restores registers, phase idle and wait multiplier five.

module led_flash_burst_sequencer import lfbs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lfbs_req_if.sink                   req_port,
   lfbs_rsp_if.source                 rsp_port,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type      cfg;
   rsp_data_type core_result;
   rsp_data_type rsp_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         accept;

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;

   lfbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lfbs_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .ms_elapsed   (req_port.ms_elapsed),
      .rand_flashes (req_port.rand_flashes),
      .rand_wait    (req_port.rand_wait),
      .cfg          (cfg),
      .result       (core_result)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.pwm_level     = rsp_data_ff.pwm_level;
   assign rsp_port.level_updated = rsp_data_ff.level_updated;
   assign rsp_port.phase         = rsp_data_ff.phase;

endmodule

`default_nettype wire

// File: hw/rtl/lfbs_csr.sv
`default_nettype none

module lfbs_csr import lfbs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_STEP_SIZE:     cfg_in.step_size        = csr_pwdata[STEP_W-1:0];
            REG_STEP_INTERVAL: cfg_in.step_interval_ms = csr_pwdata[INTERVAL_W-1:0];
            REG_IDLE_UNIT:     cfg_in.idle_unit_ms     = csr_pwdata[UNIT_W-1:0];
            REG_PAUSE_UNIT:    cfg_in.pause_unit_ms    = csr_pwdata[UNIT_W-1:0];
            REG_PEAK_LEVEL:    cfg_in.peak_level       = csr_pwdata[PEAK_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size        <= STEP_SIZE_RST;
         cfg_ff.step_interval_ms <= STEP_INTERVAL_RST;
         cfg_ff.idle_unit_ms     <= IDLE_UNIT_RST;
         cfg_ff.pause_unit_ms    <= PAUSE_UNIT_RST;
         cfg_ff.peak_level       <= PEAK_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_STEP_SIZE:     csr_prdata = {{(CSR_DATA_W-STEP_W){1'b0}}, cfg_ff.step_size};
         REG_STEP_INTERVAL: csr_prdata = {{(CSR_DATA_W-INTERVAL_W){1'b0}},
                                          cfg_ff.step_interval_ms};
         REG_IDLE_UNIT:     csr_prdata = {{(CSR_DATA_W-UNIT_W){1'b0}}, cfg_ff.idle_unit_ms};
         REG_PAUSE_UNIT:    csr_prdata = {{(CSR_DATA_W-UNIT_W){1'b0}}, cfg_ff.pause_unit_ms};
         REG_PEAK_LEVEL:    csr_prdata = {{(CSR_DATA_W-PEAK_W){1'b0}}, cfg_ff.peak_level};
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lfbs_core.sv
`default_nettype none

module lfbs_core import lfbs_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               ms_elapsed,
   input  wire logic [FLASH_W-1:0] rand_flashes,
   input  wire logic [WAIT_W-1:0]  rand_wait,
   input  wire cfg_type            cfg,
   output rsp_data_type            result
);

   logic [PHASE_W-1:0]          phase_ff, phase_in;
   logic [ELAPSED_W-1:0]        elapsed_ff, elapsed_in, elapsed_tick;
   logic signed [BRIGHT_W-1:0]  bright_ff, bright_in;
   logic [FLASH_W-1:0]          flashes_ff, flashes_in;
   logic [WAIT_W-1:0]           wait_ff, wait_in;
   logic                        updated;
   logic                        step_due;
   logic signed [BRIGHT_W-1:0]  step_s, peak_s, bright_up, bright_dn;
   logic [ELAPSED_W-1:0]        idle_limit, pause_limit;
   logic [LEVEL_W-1:0]          level;

   // tick is counted before the phase is evaluated
   assign elapsed_tick = (ms_elapsed && (elapsed_ff != ELAPSED_MAX))
                         ? elapsed_ff + 1'b1 : elapsed_ff;
   assign step_due  = elapsed_tick >= {{(ELAPSED_W-INTERVAL_W){1'b0}}, cfg.step_interval_ms};
   assign step_s    = $signed({{(BRIGHT_W-STEP_W){1'b0}}, cfg.step_size});
   assign peak_s    = $signed({{(BRIGHT_W-PEAK_W-8){1'b0}}, cfg.peak_level, 8'h00});
   assign bright_up = bright_ff + step_s;
   assign bright_dn = bright_ff - step_s;
   assign idle_limit  = {{(ELAPSED_W-WAIT_W){1'b0}}, wait_ff}
                        * {{(ELAPSED_W-UNIT_W){1'b0}}, cfg.idle_unit_ms};
   assign pause_limit = {{(ELAPSED_W-WAIT_W){1'b0}}, wait_ff}
                        * {{(ELAPSED_W-UNIT_W){1'b0}}, cfg.pause_unit_ms};

   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_tick;
      bright_in  = bright_ff;
      flashes_in = flashes_ff;
      wait_in    = wait_ff;
      updated    = 1'b0;
      unique case (phase_ff)
         PH_START: begin
            elapsed_in = '0;
            flashes_in = rand_flashes;
            wait_in    = rand_wait;
            bright_in  = '0;
            phase_in   = PH_UP;
         end
         PH_UP: begin
            if (step_due) begin
               bright_in  = bright_up;
               if (bright_up >= peak_s) phase_in = PH_DOWN;
               updated    = 1'b1;
               elapsed_in = '0;
            end
         end
         PH_DOWN: begin
            if (step_due) begin
               bright_in  = bright_dn;
               if (bright_dn <= 0) phase_in = PH_COUNT;
               updated    = 1'b1;
               elapsed_in = '0;
            end
         end
         PH_COUNT: begin
            if (flashes_ff <= 1) begin
               flashes_in = '0;
               phase_in   = PH_PAUSE;
            end else begin
               flashes_in = flashes_ff - 1'b1;
               phase_in   = PH_UP;
            end
         end
         PH_PAUSE: begin
            if (elapsed_tick >= pause_limit) phase_in = PH_START;
         end
         default: begin
            // idle, and the unreachable codes fall back to idle
            phase_in = (elapsed_tick >= idle_limit) ? PH_START : PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         elapsed_ff <= '0;
         bright_ff  <= '0;
         flashes_ff <= '0;
         wait_ff    <= WAIT_MULT_RST;
      end else if (accept) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         bright_ff  <= bright_in;
         flashes_ff <= flashes_in;
         wait_ff    <= wait_in;
      end
   end

   // integer part clamped to 0..255
   always_comb begin
      priority if (bright_in[BRIGHT_W-1]) level = '0;
      else if (bright_in[BRIGHT_W-2])     level = '1;
      else                                level = bright_in[15:8];
   end
   assign result.pwm_level     = level;
   assign result.level_updated = updated;
   assign result.phase         = phase_in;

endmodule

`default_nettype wire
